@@ design/ltps_pkg.sv @@
// ----------------------------------------------------------------------------
// Loop track position sequencer package
// Shared constants: default sizes, port widths, request opcodes and modes.
// ----------------------------------------------------------------------------
package ltps_pkg;

    localparam int LTPS_TRACK_COUNT = 8;
    localparam int LTPS_GROUP_COUNT = 4;
    localparam int LTPS_POS_BITS    = 24;

    localparam int PORT_POS_W    = 24;
    localparam int PORT_FRAMES_W = 14;
    localparam int PORT_MODE_W   = 3;
    localparam int PORT_GROUP_W  = 2;
    localparam int PORT_SLOT_W   = 3;
    localparam int PORT_TRACK_W  = 3;
    localparam int PORT_OP_W     = 2;

    localparam logic [PORT_OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [PORT_OP_W-1:0] OP_TRACK = 2'd1;
    localparam logic [PORT_OP_W-1:0] OP_SLOT  = 2'd2;

    localparam logic [PORT_MODE_W-1:0] MODE_PLAY = 3'd1;
    localparam logic [PORT_MODE_W-1:0] MODE_REC  = 3'd2;
    localparam logic [PORT_MODE_W-1:0] MODE_DUB  = 3'd3;

endpackage

@@ design/loop_track_position_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Loop track position sequencer core
// Keeps master and per-track play/record positions of a multi-track looper.
// A track or slot write request never raises busy: its result strobes on
// o_done in the next cycle. A tick request keeps busy high while one shared
// add-and-compare unit walks the slots of the selected group: a master step,
// then per empty slot a registered read of the slot table and the lookup,
// per live slot the read, the lookup with its add, the end compare and the
// group compare, then a finish step. An out-of-range group skips the walk.
// Each result is shown for exactly one cycle on o_done and cannot be held
// off; a new request may be started in that same cycle.
// ----------------------------------------------------------------------------
module loop_track_position_sequencer_core
    import ltps_pkg::*;
#(
    parameter int TRACK_COUNT = LTPS_TRACK_COUNT,
    parameter int GROUP_COUNT = LTPS_GROUP_COUNT,
    parameter int POS_BITS    = LTPS_POS_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [PORT_POS_W-1:0]    i_cfg_wdata,
    input  logic                     start,
    output logic                     busy,
    input  logic [PORT_OP_W-1:0]     i_opcode,
    input  logic [PORT_FRAMES_W-1:0] i_frame_count,
    input  logic [PORT_MODE_W-1:0]   i_mode,
    input  logic [PORT_GROUP_W-1:0]  i_group,
    input  logic [PORT_SLOT_W-1:0]   i_slot,
    input  logic [PORT_TRACK_W-1:0]  i_track_number,
    input  logic                     i_track_active,
    input  logic                     i_repeat_enable,
    input  logic [PORT_POS_W-1:0]    i_start_position,
    input  logic [PORT_POS_W-1:0]    i_current_position,
    input  logic [PORT_POS_W-1:0]    i_end_position,
    input  logic                     i_slot_filled,
    output logic                     o_done,
    output logic [PORT_MODE_W-1:0]   o_mode_after,
    output logic                     o_buffer_full,
    output logic [PORT_POS_W-1:0]    o_master_position,
    output logic [PORT_POS_W-1:0]    o_group_length
);

    localparam int SLOT_TOTAL = GROUP_COUNT * TRACK_COUNT;
    localparam int AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;
    localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
    localparam int SW = TW;
    localparam int SE_W = 1 + PORT_TRACK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MASTER,
        S_FETCH,
        S_LOOK,
        S_END,
        S_GRP,
        S_FINISH
    } t_state;

    typedef logic [POS_BITS-1:0] t_pos;

    function automatic t_pos to_pos(input logic [PORT_POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[POS_BITS-1:0];
    endfunction

    function automatic logic [PORT_POS_W-1:0] to_port(input t_pos p);
        logic [31:0] w;
        w = 32'(p);
        return w[PORT_POS_W-1:0];
    endfunction

    t_state r_state;
    logic   r_done;
    logic [PORT_MODE_W-1:0] r_mode_out;
    logic   r_full_out;
    t_pos   r_master_out;
    t_pos   r_glen_out;

    t_pos   r_limit;
    t_pos   r_master;
    t_pos   r_group_len [GROUP_COUNT];
    t_pos   r_trk_cur   [TRACK_COUNT];
    t_pos   r_trk_start [TRACK_COUNT];
    t_pos   r_trk_end   [TRACK_COUNT];
    logic   r_trk_on    [TRACK_COUNT];
    logic   r_trk_rep   [TRACK_COUNT];
    logic   r_slot_valid [SLOT_TOTAL];

    logic [SE_W-1:0] r_slot_mem [SLOT_TOTAL];
    logic [SE_W-1:0] r_rd_data;
    logic            r_rd_valid;

    logic [PORT_FRAMES_W-1:0] r_frames;
    logic [PORT_MODE_W-1:0]   r_mode;
    logic [PORT_GROUP_W-1:0]  r_grp;
    logic [PORT_SLOT_W-1:0]   r_sel;
    logic [SW-1:0]            r_slot;
    logic [TW-1:0]            r_t;
    logic                     r_rec;
    logic                     r_full;

    logic          accept;
    logic [31:0]   in_grp32;
    logic [31:0]   in_slot32;
    logic [31:0]   in_trk32;
    logic          in_grp_ok;
    logic [GW-1:0] in_g;
    logic [TW-1:0] in_t;
    logic [31:0]   wr_addr32;
    logic [AW-1:0] wr_addr;
    logic          slot_we;

    logic [31:0]   r_grp32;
    logic          grp_ok;
    logic [GW-1:0] g_idx;
    t_pos          glen_cur;
    logic [31:0]   rd_addr32;
    logic [AW-1:0] rd_addr;

    logic [31:0]   rd_trk32;
    logic [TW-1:0] t_idx;
    logic          slot_live;
    logic          rec_hit;
    logic          last_slot;

    t_pos            u_a;
    t_pos            u_b;
    t_pos            u_c;
    logic [POS_BITS:0] u_sum;
    logic            u_gt;
    t_pos            u_res;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign in_grp32  = 32'(i_group);
    assign in_slot32 = 32'(i_slot);
    assign in_trk32  = 32'(i_track_number);
    assign in_grp_ok = in_grp32 < GROUP_COUNT;
    assign in_g      = in_grp32[GW-1:0];
    assign in_t      = in_trk32[TW-1:0];
    assign wr_addr32 = in_grp32 * TRACK_COUNT + in_slot32;
    assign wr_addr   = wr_addr32[AW-1:0];
    assign slot_we   = accept && (i_opcode == OP_SLOT) && in_grp_ok
                       && (in_slot32 < TRACK_COUNT);

    assign r_grp32   = 32'(r_grp);
    assign grp_ok    = r_grp32 < GROUP_COUNT;
    assign g_idx     = r_grp32[GW-1:0];
    assign glen_cur  = grp_ok ? r_group_len[g_idx] : '0;
    assign rd_addr32 = r_grp32 * TRACK_COUNT + 32'(r_slot);
    assign rd_addr   = rd_addr32[AW-1:0];

    assign rd_trk32  = 32'(r_rd_data[PORT_TRACK_W-1:0]);
    assign t_idx     = rd_trk32[TW-1:0];
    assign slot_live = r_rd_valid && r_rd_data[SE_W-1] && (rd_trk32 < TRACK_COUNT)
                       && r_trk_on[t_idx];
    assign rec_hit   = (32'(r_slot) == 32'(r_sel))
                       && ((r_mode == MODE_REC) || (r_mode == MODE_DUB));
    assign last_slot = (32'(r_slot) == TRACK_COUNT - 1);

    // shared add and compare unit
    always_comb begin
        u_a = '0;
        u_b = '0;
        u_c = '0;
        case (r_state)
            S_MASTER: begin
                u_a = r_master;
                u_b = POS_BITS'(r_frames);
                u_c = r_limit;
            end
            S_LOOK: begin
                u_a = r_trk_cur[t_idx];
                u_b = POS_BITS'(r_frames);
                u_c = rec_hit ? r_limit : '1;
            end
            S_END: begin
                u_a = r_trk_cur[r_t];
                u_c = r_trk_end[r_t];
            end
            S_GRP: begin
                u_a = r_rec ? r_trk_end[r_t] : r_master;
                u_c = glen_cur;
            end
            S_FINISH: begin
                u_a = r_master;
                u_c = glen_cur;
            end
            default: begin
                u_a = '0;
            end
        endcase
    end

    assign u_sum = {1'b0, u_a} + {1'b0, u_b};
    assign u_gt  = u_sum > {1'b0, u_c};
    assign u_res = u_gt ? u_c : u_sum[POS_BITS-1:0];

    // slot table
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[wr_addr] <= {i_slot_filled, i_track_number};
        end
        r_rd_data <= r_slot_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_limit    <= to_pos({PORT_POS_W{1'b1}});
            r_master   <= '0;
            r_rd_valid <= 1'b0;
            for (int i = 0; i < GROUP_COUNT; i++) begin
                r_group_len[i] <= '0;
            end
            for (int i = 0; i < TRACK_COUNT; i++) begin
                r_trk_cur[i]   <= '0;
                r_trk_start[i] <= '0;
                r_trk_end[i]   <= '0;
                r_trk_on[i]    <= 1'b0;
                r_trk_rep[i]   <= 1'b0;
            end
            for (int i = 0; i < SLOT_TOTAL; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else begin
            r_done     <= 1'b0;
            r_rd_valid <= r_slot_valid[rd_addr];
            if (i_cfg_we) begin
                r_limit <= to_pos(i_cfg_wdata);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_frames <= i_frame_count;
                        r_mode   <= i_mode;
                        r_grp    <= i_group;
                        r_sel    <= i_slot;
                        r_slot   <= '0;
                        r_full   <= 1'b0;
                        if (i_opcode == OP_TICK) begin
                            r_state <= S_MASTER;
                        end else begin
                            if ((i_opcode == OP_TRACK) && (in_trk32 < TRACK_COUNT)) begin
                                r_trk_on[in_t]    <= i_track_active;
                                r_trk_rep[in_t]   <= i_repeat_enable;
                                r_trk_start[in_t] <= to_pos(i_start_position);
                                r_trk_cur[in_t]   <= to_pos(i_current_position);
                                r_trk_end[in_t]   <= to_pos(i_end_position);
                            end
                            if (slot_we) begin
                                r_slot_valid[wr_addr] <= 1'b1;
                            end
                            r_done       <= 1'b1;
                            r_mode_out   <= i_mode;
                            r_full_out   <= 1'b0;
                            r_master_out <= r_master;
                            r_glen_out   <= in_grp_ok ? r_group_len[in_g] : '0;
                        end
                    end
                end
                S_MASTER: begin
                    r_master <= u_res;
                    r_state  <= grp_ok ? S_FETCH : S_FINISH;
                end
                S_FETCH: begin
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (slot_live) begin
                        r_t              <= t_idx;
                        r_rec            <= rec_hit;
                        r_trk_cur[t_idx] <= u_res;
                        if (rec_hit && u_gt) begin
                            r_mode <= MODE_PLAY;
                            r_full <= 1'b1;
                        end
                        r_state <= S_END;
                    end else if (last_slot) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_FETCH;
                    end
                end
                S_END: begin
                    if (u_gt) begin
                        if (r_rec) begin
                            r_trk_end[r_t] <= r_trk_cur[r_t];
                        end else if (r_trk_rep[r_t]) begin
                            r_trk_cur[r_t] <= r_trk_start[r_t];
                        end
                    end
                    r_state <= S_GRP;
                end
                S_GRP: begin
                    if (u_gt) begin
                        if (r_rec) begin
                            r_group_len[g_idx] <= r_trk_end[r_t];
                        end else begin
                            r_trk_cur[r_t] <= r_trk_rep[r_t] ? r_trk_start[r_t] : '0;
                        end
                    end
                    if (last_slot) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_FETCH;
                    end
                end
                S_FINISH: begin
                    if ((r_mode == MODE_PLAY) && u_gt) begin
                        r_master     <= '0;
                        r_master_out <= '0;
                    end else begin
                        r_master_out <= r_master;
                    end
                    r_done     <= 1'b1;
                    r_mode_out <= r_mode;
                    r_full_out <= r_full;
                    r_glen_out <= glen_cur;
                    r_state    <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done            = r_done;
    assign o_mode_after      = r_mode_out;
    assign o_buffer_full     = r_full_out;
    assign o_master_position = to_port(r_master_out);
    assign o_group_length    = to_port(r_glen_out);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobed while busy");

    a_full_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_buffer_full) |-> (o_mode_after == MODE_PLAY))
        else $error("full recording did not drop to playback");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_TICK)) |=> busy)
        else $error("tick request did not start the slot walk");

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode != OP_TICK)) |=> (o_done && !o_buffer_full && !busy))
        else $error("table write request did not complete in one cycle");

endmodule
